// ===== rtl/core/bfsm_pkg.sv =====
package bfsm_pkg;

  // program symbols
  localparam logic [7:0] SYM_OPEN  = 8'h5B;
  localparam logic [7:0] SYM_CLOSE = 8'h5D;
  localparam logic [7:0] SYM_RIGHT = 8'h3E;
  localparam logic [7:0] SYM_LEFT  = 8'h3C;
  localparam logic [7:0] SYM_INC   = 8'h2B;
  localparam logic [7:0] SYM_DEC   = 8'h2D;
  localparam logic [7:0] SYM_OUT   = 8'h2E;
  localparam logic [7:0] SYM_IN    = 8'h2C;

  // item opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EXEC = 1'b1;

  // result status codes
  localparam logic [2:0] ST_LOADING  = 3'd0;
  localparam logic [2:0] ST_OK       = 3'd1;
  localparam logic [2:0] ST_CLOSE    = 3'd2;
  localparam logic [2:0] ST_OPEN     = 3'd3;
  localparam logic [2:0] ST_STEPPED  = 3'd4;
  localparam logic [2:0] ST_OUTPUT   = 3'd5;
  localparam logic [2:0] ST_INPUT    = 3'd6;
  localparam logic [2:0] ST_FINISHED = 3'd7;

  // sequencer states
  typedef enum logic [8:0] {
    S_CLEAR   = 9'b000000001,
    S_IDLE    = 9'b000000010,
    S_DECODE  = 9'b000000100,
    S_SF_STEP = 9'b000001000,
    S_SF_CMP  = 9'b000010000,
    S_SB_STEP = 9'b000100000,
    S_SB_CMP  = 9'b001000000,
    S_SETTLE  = 9'b010000000,
    S_CAPTURE = 9'b100000000
  } state_t;

  // control from the sequencer to the bracket scan unit
  typedef struct packed {
    logic clear;
    logic check;
    logic forward;
  } scan_ctl_t;

endpackage

// ===== rtl/core/bfsm_ram.sv =====
module bfsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/bfsm_scan.sv =====
module bfsm_scan #(
  parameter int NEST_W = 13
) (
  input  logic                clk,
  input  logic                rst,
  input  bfsm_pkg::scan_ctl_t ctl,
  input  logic [7:0]          sym,
  output logic                hit
);

  import bfsm_pkg::*;

  logic [NEST_W-1:0] nest;
  logic [7:0]        target;
  logic [7:0]        opener;
  logic              is_target;
  logic              is_opener;

  // bracket roles depend on scan direction
  assign target    = ctl.forward ? SYM_CLOSE : SYM_OPEN;
  assign opener    = ctl.forward ? SYM_OPEN : SYM_CLOSE;
  assign is_target = (sym == target);
  assign is_opener = (sym == opener);
  assign hit       = ctl.check && is_target && (nest == '0);

  // nesting depth of the brackets passed so far
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      nest <= '0;
    end else if (ctl.check) begin
      if (is_target && (nest != '0)) begin
        nest <= nest - NEST_W'(1);
      end else if (is_opener) begin
        nest <= nest + NEST_W'(1);
      end
    end
  end

endmodule

// ===== rtl/core/brainfuck_step_machine.sv =====
// Brainfuck machine with a program store and an 8-bit tape, one item at a time. After reset
// the tape is cleared one cell per cycle, and in_stall stays high until the pass ends. A load
// item, or an execute item that finds no valid program or no instruction left, goes through
// the settle and capture states, and any other execute item through decode first; a bracket
// jump adds a step and a compare state for every program symbol its scan reads, since the scan
// steps through the single read port of the program memory. A result waits in an output
// register, and the next item may be accepted while it is still stalled.
module brainfuck_step_machine #(
  parameter int TAPE_DEPTH    = 4096,
  parameter int PROGRAM_DEPTH = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        opcode,
  input  logic [7:0]  symbol,
  input  logic        last_symbol,
  input  logic [7:0]  in_char,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [7:0]  out_char,
  output logic [11:0] data_pointer,
  output logic [12:0] program_index
);

  import bfsm_pkg::*;

  localparam int TW = $clog2(TAPE_DEPTH);
  localparam int PW = $clog2(PROGRAM_DEPTH);
  localparam int CW = $clog2(PROGRAM_DEPTH + 1);

  state_t        state;
  logic [TW-1:0] clear_addr;
  logic [TW-1:0] tape_pointer;
  logic [CW-1:0] instruction_index;
  logic [CW-1:0] program_length;
  logic [CW-1:0] load_position;
  logic [CW-1:0] load_depth;
  logic          load_error;
  logic          program_valid;
  logic [CW-1:0] scan_pos;
  logic [7:0]    item_char;
  logic [2:0]    result_status;

  logic [CW-1:0] pos_next;
  logic [CW-1:0] depth_next;
  logic          error_next;
  logic          room;
  logic          accept;
  logic          finished;
  logic [CW-1:0] scan_up;
  logic [CW-1:0] scan_down;

  logic          prog_we;
  logic [PW-1:0] prog_raddr;
  logic [7:0]    prog_rdata;
  logic          tape_we;
  logic [TW-1:0] tape_waddr;
  logic [7:0]    tape_wdata;
  logic [7:0]    tape_rdata;

  scan_ctl_t     scan_ctl;
  logic          scan_hit;

  logic [31:0]   tp_wide;
  logic [31:0]   idx_wide;
  logic          capture_fire;

  assign accept       = in_valid && (state == S_IDLE);
  assign in_stall     = (state != S_IDLE);
  assign finished     = !program_valid || (instruction_index >= program_length);
  assign scan_up      = scan_pos + CW'(1);
  assign scan_down    = scan_pos - CW'(1);
  assign tp_wide      = 32'(tape_pointer);
  assign idx_wide     = 32'(instruction_index);
  assign capture_fire = (state == S_CAPTURE) && !(out_valid && out_stall);

  // running bracket check for a load item
  always_comb begin
    room       = (load_position < CW'(PROGRAM_DEPTH));
    pos_next   = load_position;
    depth_next = load_depth;
    error_next = load_error;
    if (room) begin
      pos_next = load_position + CW'(1);
      if (!load_error) begin
        if (symbol == SYM_OPEN) begin
          depth_next = load_depth + CW'(1);
        end else if (symbol == SYM_CLOSE) begin
          if (load_depth == '0) begin
            error_next = 1'b1;
          end else begin
            depth_next = load_depth - CW'(1);
          end
        end
      end
    end
  end

  // program memory ports
  always_comb begin
    prog_we    = accept && (opcode == OP_LOAD) && room;
    prog_raddr = instruction_index[PW-1:0];
    if (state == S_SF_STEP) begin
      prog_raddr = scan_up[PW-1:0];
    end else if (state == S_SB_STEP) begin
      prog_raddr = scan_down[PW-1:0];
    end
  end

  // tape memory write port, also used by the clearing pass
  always_comb begin
    tape_we    = 1'b0;
    tape_waddr = tape_pointer;
    tape_wdata = tape_rdata;
    if (state == S_CLEAR) begin
      tape_we    = 1'b1;
      tape_waddr = clear_addr;
      tape_wdata = '0;
    end else if (state == S_DECODE) begin
      if (prog_rdata == SYM_INC) begin
        tape_we    = 1'b1;
        tape_wdata = tape_rdata + 8'd1;
      end else if (prog_rdata == SYM_DEC) begin
        tape_we    = 1'b1;
        tape_wdata = tape_rdata - 8'd1;
      end else if (prog_rdata == SYM_IN) begin
        tape_we    = 1'b1;
        tape_wdata = item_char;
      end
    end
  end

  // scan unit control
  always_comb begin
    scan_ctl.clear   = (state == S_DECODE);
    scan_ctl.check   = (state == S_SF_CMP) || (state == S_SB_CMP);
    scan_ctl.forward = (state == S_SF_CMP);
  end

  bfsm_ram #(
    .WIDTH(8),
    .DEPTH(PROGRAM_DEPTH)
  ) u_prog_ram (
    .clk  (clk),
    .we   (prog_we),
    .waddr(load_position[PW-1:0]),
    .wdata(symbol),
    .raddr(prog_raddr),
    .rdata(prog_rdata)
  );

  bfsm_ram #(
    .WIDTH(8),
    .DEPTH(TAPE_DEPTH)
  ) u_tape_ram (
    .clk  (clk),
    .we   (tape_we),
    .waddr(tape_waddr),
    .wdata(tape_wdata),
    .raddr(tape_pointer),
    .rdata(tape_rdata)
  );

  bfsm_scan #(
    .NEST_W(CW)
  ) u_scan (
    .clk(clk),
    .rst(rst),
    .ctl(scan_ctl),
    .sym(prog_rdata),
    .hit(scan_hit)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_CLEAR;
      clear_addr        <= '0;
      tape_pointer      <= '0;
      instruction_index <= '0;
      program_length    <= '0;
      load_position     <= '0;
      load_depth        <= '0;
      load_error        <= 1'b0;
      program_valid     <= 1'b0;
      result_status     <= ST_LOADING;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clear_addr <= clear_addr + TW'(1);
          if (clear_addr == TW'(TAPE_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            item_char <= in_char;
            if (opcode == OP_LOAD) begin
              program_valid <= 1'b0;
              result_status <= ST_LOADING;
              load_position <= pos_next;
              load_depth    <= depth_next;
              load_error    <= error_next;
              if (last_symbol) begin
                load_position <= '0;
                load_depth    <= '0;
                load_error    <= 1'b0;
                if (error_next) begin
                  result_status <= ST_CLOSE;
                end else if (depth_next != '0) begin
                  result_status <= ST_OPEN;
                end else begin
                  result_status     <= ST_OK;
                  program_valid     <= 1'b1;
                  program_length    <= pos_next;
                  instruction_index <= '0;
                end
              end
              state <= S_SETTLE;
            end else if (finished) begin
              result_status <= ST_FINISHED;
              state         <= S_SETTLE;
            end else begin
              state <= S_DECODE;
            end
          end
        end
        S_DECODE: begin
          result_status     <= ST_STEPPED;
          instruction_index <= instruction_index + CW'(1);
          scan_pos          <= instruction_index;
          state             <= S_SETTLE;
          unique case (prog_rdata)
            SYM_RIGHT: begin
              tape_pointer <= (tape_pointer == TW'(TAPE_DEPTH - 1)) ? '0
                              : tape_pointer + TW'(1);
            end
            SYM_LEFT: begin
              tape_pointer <= (tape_pointer == '0) ? TW'(TAPE_DEPTH - 1)
                              : tape_pointer - TW'(1);
            end
            SYM_OUT: result_status <= ST_OUTPUT;
            SYM_IN:  result_status <= ST_INPUT;
            SYM_OPEN: begin
              if (tape_rdata == 8'd0) begin
                instruction_index <= instruction_index;
                state             <= S_SF_STEP;
              end
            end
            SYM_CLOSE: begin
              if (tape_rdata != 8'd0) begin
                instruction_index <= instruction_index;
                state             <= S_SB_STEP;
              end
            end
            default: ;
          endcase
        end
        // forward scan: advance, stop at the program end
        S_SF_STEP: begin
          if (scan_up >= program_length) begin
            instruction_index <= program_length;
            state             <= S_SETTLE;
          end else begin
            scan_pos <= scan_up;
            state    <= S_SF_CMP;
          end
        end
        S_SF_CMP: begin
          if (scan_hit) begin
            instruction_index <= scan_up;
            state             <= S_SETTLE;
          end else begin
            state <= S_SF_STEP;
          end
        end
        // backward scan: step down, stop at position zero
        S_SB_STEP: begin
          if (scan_pos == '0) begin
            instruction_index <= CW'(1);
            state             <= S_SETTLE;
          end else begin
            scan_pos <= scan_down;
            state    <= S_SB_CMP;
          end
        end
        S_SB_CMP: begin
          if (scan_hit) begin
            instruction_index <= scan_up;
            state             <= S_SETTLE;
          end else begin
            state <= S_SB_STEP;
          end
        end
        // tape read at the final pointer is in flight
        S_SETTLE: state <= S_CAPTURE;
        S_CAPTURE: begin
          if (capture_fire) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (capture_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (capture_fire) begin
      status        <= result_status;
      out_char      <= tape_rdata;
      data_pointer  <= tp_wide[11:0];
      program_index <= idx_wide[12:0];
    end
  end

endmodule

// ===== rtl/core/bfsm_checker.sv =====
module bfsm_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  status,
  input logic [7:0]  out_char,
  input logic [11:0] data_pointer,
  input logic [12:0] program_index
);

  import bfsm_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(out_char)
      && $stable(data_pointer) && $stable(program_index))
    else $error("stalled result changed");

  // tape clearing keeps the input closed right after reset
  a_clear_after_reset: assert property (@(posedge clk)
    !rst && $past(rst) |-> in_stall)
    else $error("item accepted during tape clear");

  // one item at a time
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second item accepted back to back");

  // an accepted program restarts at its first instruction
  a_ok_restarts: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_OK) |-> (program_index == 13'd0))
    else $error("accepted program does not restart at zero");

endmodule

bind brainfuck_step_machine bfsm_checker u_bfsm_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .status       (status),
  .out_char     (out_char),
  .data_pointer (data_pointer),
  .program_index(program_index)
);
